FILE: rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// shared codes, widths and control/status types of the rational arithmetic unit
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int MODE_W        = 3;
  localparam int ORDER_W       = 2;
  localparam int OP_W          = 4;
  localparam int DSRC_W        = 2;

  // operation selector carried by each input word
  localparam logic [MODE_W-1:0] MODE_LOAD = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ADD  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SUB  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MUL  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DIV  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CMP  = 3'd5;

  // order codes
  localparam logic [ORDER_W-1:0] ORD_EQ = 2'b00;
  localparam logic [ORDER_W-1:0] ORD_GT = 2'b01;
  localparam logic [ORDER_W-1:0] ORD_LT = 2'b11;

  // datapath register-transfer ops
  localparam logic [OP_W-1:0] OP_IDLE     = 4'd0;
  localparam logic [OP_W-1:0] OP_CAPTURE  = 4'd1;
  localparam logic [OP_W-1:0] OP_LOAD     = 4'd2;
  localparam logic [OP_W-1:0] OP_NAN      = 4'd3;
  localparam logic [OP_W-1:0] OP_WR_P     = 4'd4;
  localparam logic [OP_W-1:0] OP_WR_Q     = 4'd5;
  localparam logic [OP_W-1:0] OP_WR_AD    = 4'd6;
  localparam logic [OP_W-1:0] OP_CMP      = 4'd7;
  localparam logic [OP_W-1:0] OP_SET      = 4'd8;
  localparam logic [OP_W-1:0] OP_SUM      = 4'd9;
  localparam logic [OP_W-1:0] OP_EUC_INIT = 4'd10;
  localparam logic [OP_W-1:0] OP_EUC_STEP = 4'd11;
  localparam logic [OP_W-1:0] OP_AN_QUO   = 4'd12;
  localparam logic [OP_W-1:0] OP_AD_QUO   = 4'd13;
  localparam logic [OP_W-1:0] OP_EMIT     = 4'd14;

  // divider operand sources
  localparam logic [DSRC_W-1:0] DIV_XY = 2'd0;
  localparam logic [DSRC_W-1:0] DIV_AN = 2'd1;
  localparam logic [DSRC_W-1:0] DIV_AD = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic              start;      // launch the shared mul/div unit
    logic              is_div;
    logic              mul_a_den;  // multiplicand: 0 acc_num, 1 acc_den
    logic              mul_b_den;  // multiplier: 0 operand_num, 1 operand_den
    logic [DSRC_W-1:0] div_src;
  } rau_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              fd_zero;
    logic              y_zero;
    logic              g_trivial;  // gcd is one or zero
    logic              pass_end;
    logic              mdu_done;
  } rau_stat_t;

endpackage

FILE: rtl/rau_mdu.sv
// ----------------------------------------------------------------------------
// rau_mdu
// shared iterative unit: wrapping shift-add multiply or truncating signed
// divide with remainder, one bit per cycle
// ----------------------------------------------------------------------------
module rau_mdu #(
  parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 is_div,
  input  logic [WORD_BITS-1:0] a,
  input  logic [WORD_BITS-1:0] b,
  output logic                 done,
  output logic [WORD_BITS-1:0] prod,
  output logic [WORD_BITS-1:0] quo,
  output logic [WORD_BITS-1:0] rem
);

  localparam int W     = WORD_BITS;
  localparam int CNT_W = $clog2(W);

  logic [W-1:0]     acc;
  logic [W-1:0]     sh;
  logic [W-1:0]     dv;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             div_mode;
  logic             neg_q;
  logic             neg_r;
  logic [W:0]       shifted;
  logic [W:0]       diff;
  logic [W-1:0]     mag_a;
  logic [W-1:0]     mag_b;

  assign mag_a   = a[W-1] ? (W'(0) - a) : a;
  assign mag_b   = b[W-1] ? (W'(0) - b) : b;
  assign shifted = {acc, sh[W-1]};
  assign diff    = shifted - {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc      <= '0;
      cnt      <= '0;
      div_mode <= is_div;
      neg_q    <= a[W-1] ^ b[W-1];
      neg_r    <= a[W-1];
      if (is_div) begin
        sh <= mag_a;
        dv <= mag_b;
      end else begin
        sh <= b;
        dv <= a;
      end
    end else if (busy) begin
      cnt <= cnt + CNT_W'(1);
      if (div_mode) begin
        // restoring step on magnitudes
        if (!diff[W]) begin
          acc <= diff[W-1:0];
          sh  <= {sh[W-2:0], 1'b1};
        end else begin
          acc <= shifted[W-1:0];
          sh  <= {sh[W-2:0], 1'b0};
        end
      end else begin
        if (sh[0]) begin
          acc <= acc + dv;
        end
        dv <= {dv[W-2:0], 1'b0};
        sh <= {1'b0, sh[W-1:1]};
      end
    end
  end

  assign prod = acc;
  assign quo  = neg_q ? (W'(0) - sh) : sh;
  assign rem  = neg_r ? (W'(0) - acc) : acc;

endmodule

FILE: rtl/rau_dpath.sv
// ----------------------------------------------------------------------------
// rau_dpath
// accumulator, operand, product and gcd registers with the output register
// ----------------------------------------------------------------------------
module rau_dpath #(
  parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  rau_pkg::rau_cmd_t            cmd,
  output rau_pkg::rau_stat_t           stat,
  input  logic [rau_pkg::MODE_W-1:0]   in_mode,
  input  logic [WORD_BITS-1:0]         in_num,
  input  logic [WORD_BITS-1:0]         in_den,
  output logic [WORD_BITS-1:0]         result_num,
  output logic [WORD_BITS-1:0]         result_den,
  output logic [rau_pkg::ORDER_W-1:0]  order,
  output logic                         same_fields,
  output logic                         whole_number,
  output logic                         not_a_number
);

  localparam int W          = WORD_BITS;
  localparam int MAX_PASSES = 2 * W + 4;
  localparam int PASS_W     = $clog2(MAX_PASSES + 1);

  logic [rau_pkg::MODE_W-1:0]  mode;
  logic [W-1:0]                fn;
  logic [W-1:0]                fd;
  logic [W-1:0]                an;
  logic [W-1:0]                ad;
  logic [W-1:0]                p;
  logic [W-1:0]                q;
  logic [W-1:0]                x;
  logic [W-1:0]                y;
  logic [PASS_W-1:0]           pass;
  logic [rau_pkg::ORDER_W-1:0] ord;

  logic [W-1:0] mdu_a;
  logic [W-1:0] mdu_b;
  logic         mdu_done;
  logic [W-1:0] mdu_prod;
  logic [W-1:0] mdu_quo;
  logic [W-1:0] mdu_rem;

  always_comb begin
    if (cmd.is_div) begin
      case (cmd.div_src)
        rau_pkg::DIV_XY: begin
          mdu_a = x;
          mdu_b = y;
        end
        rau_pkg::DIV_AN: begin
          mdu_a = an;
          mdu_b = x;
        end
        default: begin
          mdu_a = ad;
          mdu_b = x;
        end
      endcase
    end else begin
      mdu_a = cmd.mul_a_den ? ad : an;
      mdu_b = cmd.mul_b_den ? fd : fn;
    end
  end

  rau_mdu #(
    .WORD_BITS(W)
  ) u_mdu (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.start),
    .is_div(cmd.is_div),
    .a     (mdu_a),
    .b     (mdu_b),
    .done  (mdu_done),
    .prod  (mdu_prod),
    .quo   (mdu_quo),
    .rem   (mdu_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      an   <= '0;
      ad   <= W'(1);
      pass <= '0;
    end else begin
      case (cmd.op)
        rau_pkg::OP_LOAD: begin
          an   <= fn;
          ad   <= fd;
          pass <= '0;
        end
        rau_pkg::OP_NAN: begin
          if (ad == '0 || fd == '0) begin
            ad <= '0;
          end
          pass <= '0;
        end
        rau_pkg::OP_WR_AD: begin
          ad <= mdu_prod;
        end
        rau_pkg::OP_SET: begin
          an <= p;
          ad <= q;
        end
        rau_pkg::OP_SUM: begin
          an <= (mode == rau_pkg::MODE_ADD) ? (p + q) : (p - q);
        end
        rau_pkg::OP_AN_QUO: begin
          an <= mdu_quo;
        end
        rau_pkg::OP_AD_QUO: begin
          ad   <= mdu_quo;
          pass <= pass + PASS_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      rau_pkg::OP_CAPTURE: begin
        mode <= in_mode;
        fn   <= in_num;
        fd   <= in_den;
        ord  <= rau_pkg::ORD_EQ;
      end
      rau_pkg::OP_WR_P: begin
        p <= mdu_prod;
      end
      rau_pkg::OP_WR_Q: begin
        q <= mdu_prod;
      end
      rau_pkg::OP_CMP: begin
        if ($signed(p) > $signed(q)) begin
          ord <= rau_pkg::ORD_GT;
        end else if ($signed(p) < $signed(q)) begin
          ord <= rau_pkg::ORD_LT;
        end else begin
          ord <= rau_pkg::ORD_EQ;
        end
      end
      rau_pkg::OP_EUC_INIT: begin
        x <= an;
        y <= ad;
      end
      rau_pkg::OP_EUC_STEP: begin
        x <= y;
        y <= mdu_rem;
      end
      rau_pkg::OP_EMIT: begin
        result_num   <= an;
        result_den   <= ad;
        order        <= ord;
        same_fields  <= (an == fn) && (ad == fd);
        whole_number <= (ad == W'(1));
        not_a_number <= (ad == '0);
      end
      default: begin
      end
    endcase
  end

  assign stat.mode      = mode;
  assign stat.fd_zero   = (fd == '0);
  assign stat.y_zero    = (y == '0);
  assign stat.g_trivial = (x == W'(1)) || (x == '0);
  assign stat.pass_end  = (pass == PASS_W'(MAX_PASSES));
  assign stat.mdu_done  = mdu_done;

endmodule

FILE: rtl/rau_ctrl.sv
// ----------------------------------------------------------------------------
// rau_ctrl
// sequencer: products, euclid gcd passes, reduction and word handshakes
// ----------------------------------------------------------------------------
module rau_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  input  rau_pkg::rau_stat_t stat,
  output rau_pkg::rau_cmd_t  cmd
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_DISPATCH = 5'd1;
  localparam logic [4:0] S_M1       = 5'd2;
  localparam logic [4:0] S_W1       = 5'd3;
  localparam logic [4:0] S_M2       = 5'd4;
  localparam logic [4:0] S_W2       = 5'd5;
  localparam logic [4:0] S_COMBINE  = 5'd6;
  localparam logic [4:0] S_M3       = 5'd7;
  localparam logic [4:0] S_W3       = 5'd8;
  localparam logic [4:0] S_SUM      = 5'd9;
  localparam logic [4:0] S_R_INIT   = 5'd10;
  localparam logic [4:0] S_R_TEST   = 5'd11;
  localparam logic [4:0] S_R_WREM   = 5'd12;
  localparam logic [4:0] S_R_G      = 5'd13;
  localparam logic [4:0] S_R_WAN    = 5'd14;
  localparam logic [4:0] S_R_DAD    = 5'd15;
  localparam logic [4:0] S_R_WAD    = 5'd16;
  localparam logic [4:0] S_EMIT     = 5'd17;

  logic [4:0] state;
  logic [4:0] state_next;
  logic       out_free;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next    = state;
    cmd.op        = rau_pkg::OP_IDLE;
    cmd.start     = 1'b0;
    cmd.is_div    = 1'b0;
    cmd.mul_a_den = 1'b0;
    cmd.mul_b_den = 1'b0;
    cmd.div_src   = rau_pkg::DIV_XY;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.op     = rau_pkg::OP_CAPTURE;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.mode)
          rau_pkg::MODE_LOAD: begin
            cmd.op     = rau_pkg::OP_LOAD;
            state_next = stat.fd_zero ? S_EMIT : S_R_INIT;
          end
          rau_pkg::MODE_ADD, rau_pkg::MODE_SUB, rau_pkg::MODE_MUL, rau_pkg::MODE_DIV: begin
            cmd.op     = rau_pkg::OP_NAN;
            state_next = S_M1;
          end
          rau_pkg::MODE_CMP: begin
            state_next = S_M1;
          end
          default: begin
            state_next = S_EMIT;
          end
        endcase
      end
      S_M1: begin
        cmd.start     = 1'b1;
        cmd.mul_b_den = (stat.mode != rau_pkg::MODE_MUL);
        state_next    = S_W1;
      end
      S_W1: begin
        if (stat.mdu_done) begin
          cmd.op     = rau_pkg::OP_WR_P;
          state_next = S_M2;
        end
      end
      S_M2: begin
        cmd.start     = 1'b1;
        cmd.mul_a_den = 1'b1;
        cmd.mul_b_den = (stat.mode == rau_pkg::MODE_MUL);
        state_next    = S_W2;
      end
      S_W2: begin
        if (stat.mdu_done) begin
          cmd.op     = rau_pkg::OP_WR_Q;
          state_next = S_COMBINE;
        end
      end
      S_COMBINE: begin
        if (stat.mode == rau_pkg::MODE_CMP) begin
          cmd.op     = rau_pkg::OP_CMP;
          state_next = S_EMIT;
        end else if (stat.mode == rau_pkg::MODE_ADD || stat.mode == rau_pkg::MODE_SUB) begin
          state_next = S_M3;
        end else begin
          cmd.op     = rau_pkg::OP_SET;
          state_next = S_R_INIT;
        end
      end
      S_M3: begin
        cmd.start     = 1'b1;
        cmd.mul_a_den = 1'b1;
        cmd.mul_b_den = 1'b1;
        state_next    = S_W3;
      end
      S_W3: begin
        if (stat.mdu_done) begin
          cmd.op     = rau_pkg::OP_WR_AD;
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        cmd.op     = rau_pkg::OP_SUM;
        state_next = S_R_INIT;
      end
      S_R_INIT: begin
        if (stat.pass_end) begin
          state_next = S_EMIT;
        end else begin
          cmd.op     = rau_pkg::OP_EUC_INIT;
          state_next = S_R_TEST;
        end
      end
      S_R_TEST: begin
        if (stat.y_zero) begin
          state_next = S_R_G;
        end else begin
          cmd.start   = 1'b1;
          cmd.is_div  = 1'b1;
          cmd.div_src = rau_pkg::DIV_XY;
          state_next  = S_R_WREM;
        end
      end
      S_R_WREM: begin
        if (stat.mdu_done) begin
          cmd.op     = rau_pkg::OP_EUC_STEP;
          state_next = S_R_TEST;
        end
      end
      S_R_G: begin
        if (stat.g_trivial) begin
          state_next = S_EMIT;
        end else begin
          cmd.start   = 1'b1;
          cmd.is_div  = 1'b1;
          cmd.div_src = rau_pkg::DIV_AN;
          state_next  = S_R_WAN;
        end
      end
      S_R_WAN: begin
        if (stat.mdu_done) begin
          cmd.op     = rau_pkg::OP_AN_QUO;
          state_next = S_R_DAD;
        end
      end
      S_R_DAD: begin
        cmd.start   = 1'b1;
        cmd.is_div  = 1'b1;
        cmd.div_src = rau_pkg::DIV_AD;
        state_next  = S_R_WAD;
      end
      S_R_WAD: begin
        if (stat.mdu_done) begin
          cmd.op     = rau_pkg::OP_AD_QUO;
          state_next = S_R_INIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.op     = rau_pkg::OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.op == rau_pkg::OP_EMIT) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// accumulator fraction with load, add, subtract, multiply, divide and compare,
// reduced after each change by repeated euclid gcd
// ----------------------------------------------------------------------------
//
//   channel   dir   payload (lsb first)                         handshake
//   s_*       in    mode, operand_num, operand_den              tvalid/tready
//   m_*       out   result_num, result_den, order,              tvalid/tready
//                   same_fields, whole_number, not_a_number
//
// one word is worked on at a time; every multiply, remainder and quotient runs
// on a single shared shift-add / restoring unit; an item costs 2 to 3 products
// (none for a load) plus, per reduction pass, one remainder per euclid step
// (up to about 46) and two quotients; a common factor or a negative gcd forces
// extra passes
// rst (synchronous, high) gives acc 0/1 and an empty output register
// a finished result waits in the output register while the next word is
// taken; the sequencer only stalls if a second result is ready before then
//
module rational_arithmetic_unit #(
  parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // input words
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // mode, operand_num, operand_den, zero pad
  input  logic [((3 + 2 * WORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  // result words
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // result_num, result_den, order, same_fields, whole_number, not_a_number, zero pad
  output logic [((5 + 2 * WORD_BITS + 7) / 8) * 8 - 1:0] m_tdata
);

  localparam int W      = WORD_BITS;
  localparam int MW     = rau_pkg::MODE_W;
  localparam int OW     = rau_pkg::ORDER_W;
  localparam int OUT_W  = 2 * W + OW + 3;
  localparam int OUT_TW = ((5 + 2 * WORD_BITS + 7) / 8) * 8;

  rau_pkg::rau_cmd_t  cmd;
  rau_pkg::rau_stat_t stat;

  logic [W-1:0]  result_num;
  logic [W-1:0]  result_den;
  logic [OW-1:0] order;
  logic          same_fields;
  logic          whole_number;
  logic          not_a_number;
  logic [OUT_W-1:0] out_word;

  // sequencer: owns both handshakes
  rau_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  // registers, shared mul/div unit and result register
  rau_dpath #(
    .WORD_BITS(W)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_mode     (s_tdata[MW-1:0]),
    .in_num      (s_tdata[MW +: W]),
    .in_den      (s_tdata[MW + W +: W]),
    .result_num  (result_num),
    .result_den  (result_den),
    .order       (order),
    .same_fields (same_fields),
    .whole_number(whole_number),
    .not_a_number(not_a_number)
  );

  // pack the result word, pad bits zero
  assign out_word = {not_a_number, whole_number, same_fields, order, result_den, result_num};
  assign m_tdata  = OUT_TW'(out_word);

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives operation words into the rational arithmetic unit and checks every
// result word against a fraction predictor kept in a small scoreboard; a
// directed run of corner cases is followed by random words, with random gaps
// on both sides, a quiet stretch and one full drain in between
// ----------------------------------------------------------------------------
module testbench;

  localparam int W           = rau_pkg::WORD_BITS_DEF;
  localparam int S_W         = ((3 + 2 * W + 7) / 8) * 8;
  localparam int M_W         = ((5 + 2 * W + 7) / 8) * 8;
  localparam int MAX_PASSES  = 2 * W + 4;
  localparam int RAND_WORDS  = 370;
  localparam int DRAIN_TAIL  = 2000;
  localparam int CYCLE_LIMIT = 12000000;

  // the two mode codes that the block leaves unused
  localparam logic [rau_pkg::MODE_W-1:0] MODE_SPARE_LO = 3'd6;
  localparam logic [rau_pkg::MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  // one expected result word, fields unpacked
  typedef struct {
    logic [W-1:0]                num;
    logic [W-1:0]                den;
    logic [rau_pkg::ORDER_W-1:0] ord;
    logic                        same;
    logic                        whole;
    logic                        nan;
  } frac_result_t;

  // --------------------------------------------------------------------------
  // scoreboard: running accumulator fraction plus the queue of owed results
  // --------------------------------------------------------------------------
  class frac_scoreboard;
    logic [W-1:0] acc_num;
    logic [W-1:0] acc_den;
    frac_result_t owed[$];
    int unsigned  mismatches;
    int unsigned  checked;
    int unsigned  nan_seen;

    function new();
      acc_num    = '0;
      acc_den    = 1;
      mismatches = 0;
      checked    = 0;
      nan_seen   = 0;
    endfunction

    // unsigned magnitude; the most negative word maps to 2**(W-1)
    function logic [W-1:0] mag(logic [W-1:0] x);
      return x[W-1] ? -x : x;
    endfunction

    // truncating signed quotient, wraps on most negative / -1
    function logic [W-1:0] trunc_quo(logic [W-1:0] x, logic [W-1:0] y);
      logic [W-1:0] q;
      q = mag(x) / mag(y);
      return (x[W-1] != y[W-1]) ? -q : q;
    endfunction

    // truncating signed remainder, takes the dividend's sign
    function logic [W-1:0] trunc_rem(logic [W-1:0] x, logic [W-1:0] y);
      logic [W-1:0] r;
      r = mag(x) % mag(y);
      return x[W-1] ? -r : r;
    endfunction

    function logic [W-1:0] euclid_gcd(logic [W-1:0] x, logic [W-1:0] y);
      logic [W-1:0] t;
      while (y != 0) begin
        t = y;
        y = trunc_rem(x, y);
        x = t;
      end
      return x;
    endfunction

    // divide both parts by the gcd until it is trivial or the pass bound hits
    function void reduce_acc();
      logic [W-1:0] g;
      for (int pass = 0; pass < MAX_PASSES; pass++) begin
        g = euclid_gcd(acc_num, acc_den);
        if (g == 1 || g == 0) break;
        acc_num = trunc_quo(acc_num, g);
        acc_den = trunc_quo(acc_den, g);
      end
    endfunction

    // apply one accepted word and queue the result it owes
    function void note_input(logic [rau_pkg::MODE_W-1:0] mode, logic [W-1:0] fn,
                             logic [W-1:0] fd);
      frac_result_t r;
      logic [W-1:0] p;
      logic [W-1:0] q;
      r.ord = rau_pkg::ORD_EQ;
      case (mode)
        rau_pkg::MODE_LOAD: begin
          acc_num = fn;
          acc_den = fd;
          if (acc_den != 0) reduce_acc();
        end
        rau_pkg::MODE_ADD, rau_pkg::MODE_SUB, rau_pkg::MODE_MUL, rau_pkg::MODE_DIV: begin
          // a zero denominator on either side poisons the result
          if (acc_den == 0 || fd == 0) acc_den = '0;
          case (mode)
            rau_pkg::MODE_ADD, rau_pkg::MODE_SUB: begin
              p = acc_num * fd;
              q = acc_den * fn;
              acc_num = (mode == rau_pkg::MODE_ADD) ? p + q : p - q;
              acc_den = acc_den * fd;
            end
            rau_pkg::MODE_MUL: begin
              acc_num = acc_num * fn;
              acc_den = acc_den * fd;
            end
            default: begin
              acc_num = acc_num * fd;
              acc_den = acc_den * fn;
            end
          endcase
          reduce_acc();
        end
        rau_pkg::MODE_CMP: begin
          p = acc_num * fd;
          q = acc_den * fn;
          if ($signed(p) > $signed(q)) r.ord = rau_pkg::ORD_GT;
          else if ($signed(p) < $signed(q)) r.ord = rau_pkg::ORD_LT;
        end
        default: ;
      endcase
      r.num   = acc_num;
      r.den   = acc_den;
      r.same  = (acc_num == fn) && (acc_den == fd);
      r.whole = (acc_den == 1);
      r.nan   = (acc_den == 0);
      owed.push_back(r);
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function void field_check(string name, logic [W-1:0] exp_v, logic [W-1:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
        mismatches++;
      end
    endfunction

    function void check_result(logic [M_W-1:0] word);
      frac_result_t e;
      if (owed.size() == 0) begin
        $error("result word %h arrived with nothing expected", word);
        mismatches++;
        return;
      end
      e = owed.pop_front();
      checked++;
      if (e.nan) nan_seen++;
      field_check("result_num", e.num, word[W-1:0]);
      field_check("result_den", e.den, word[2*W-1:W]);
      field_check("order", W'(e.ord), W'(word[2*W+1:2*W]));
      field_check("same_fields", W'(e.same), W'(word[2*W+2]));
      field_check("whole_number", W'(e.whole), W'(word[2*W+3]));
      field_check("not_a_number", W'(e.nan), W'(word[2*W+4]));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block
  // --------------------------------------------------------------------------
  logic           clk      = 1'b0;
  logic           rst      = 1'b1;
  logic           s_tvalid = 1'b0;
  logic           s_tready;
  logic [S_W-1:0] s_tdata  = '0;   // mode, operand_num, operand_den, zero pad
  logic           m_tvalid;
  logic           m_tready = 1'b0;
  logic [M_W-1:0] m_tdata;         // result_num, result_den, order, same_fields,
                                   // whole_number, not_a_number, zero pad

  frac_scoreboard sb = new();
  bit             quiet = 1'b0;    // no idling on either side while set
  int unsigned    cycles = 0;
  int unsigned    mode_count [8];

  always #2 clk = ~clk;

  rational_arithmetic_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(50, 400);
  endfunction

  // operand values: mostly small so reduction has work, plus wide and extreme ones
  function automatic logic [W-1:0] rand_word(int zero_pct);
    logic [W-1:0] v;
    if ($urandom_range(0, 99) < zero_pct) return '0;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: v = $urandom_range(1, 60);
      6: v = $urandom_range(1, 100000);
      7, 8: v = $urandom;
      default: begin
        case ($urandom_range(0, 3))
          0: v = 1;
          1: v = {1'b1, {(W-1){1'b0}}};
          2: v = {1'b0, {(W-1){1'b1}}};
          default: v = '1;
        endcase
        return v;
      end
    endcase
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  // --------------------------------------------------------------------------
  // input side: one word per call, returns at the edge that accepted it
  // --------------------------------------------------------------------------
  task automatic push_word(input logic [rau_pkg::MODE_W-1:0] mode, input logic [W-1:0] fn,
                           input logic [W-1:0] fd);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_W - 3 - 2 * W){1'b0}}, fd, fn, mode};
    do @(posedge clk); while (!s_tready);
    sb.note_input(mode, fn, fd);
    mode_count[mode]++;
  endtask

  task automatic random_word();
    logic [rau_pkg::MODE_W-1:0] mode;
    logic [W-1:0]               fn;
    logic [W-1:0]               fd;
    int                         r;
    r = $urandom_range(0, 99);
    if (r < 16) mode = rau_pkg::MODE_LOAD;
    else if (r < 30) mode = rau_pkg::MODE_ADD;
    else if (r < 44) mode = rau_pkg::MODE_SUB;
    else if (r < 58) mode = rau_pkg::MODE_MUL;
    else if (r < 72) mode = rau_pkg::MODE_DIV;
    else if (r < 92) mode = rau_pkg::MODE_CMP;
    else mode = $urandom_range(0, 1) ? MODE_SPARE_HI : MODE_SPARE_LO;
    fn = rand_word(6);
    fd = rand_word(3);
    // compare against the accumulator itself or a scaled copy to hit equality
    if (mode == rau_pkg::MODE_CMP && $urandom_range(0, 3) == 0) begin
      fn = sb.acc_num;
      fd = sb.acc_den;
      if ($urandom_range(0, 1)) begin
        fn = fn * 3;
        fd = fd * 3;
      end
    end
    push_word(mode, fn, fd);
  endtask

  // --------------------------------------------------------------------------
  // output side: check accepted words, stall ready at random
  // --------------------------------------------------------------------------
  int stall_left = 0;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** rational_arithmetic_unit: FAILED **");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: plain arithmetic on small fractions
    push_word(rau_pkg::MODE_LOAD, 6, 4);        // reduces to 3/2
    push_word(rau_pkg::MODE_ADD, 1, 3);
    push_word(rau_pkg::MODE_SUB, 5, 7);
    push_word(rau_pkg::MODE_MUL, -4, 9);
    push_word(rau_pkg::MODE_DIV, 2, -3);
    push_word(rau_pkg::MODE_CMP, 1, 2);
    push_word(rau_pkg::MODE_CMP, -1000, 1);
    // equal value with different fields, then identical fields
    push_word(rau_pkg::MODE_LOAD, 3, 4);
    push_word(rau_pkg::MODE_CMP, 6, 8);
    push_word(rau_pkg::MODE_CMP, 3, 4);
    push_word(rau_pkg::MODE_SUB, 3, 4);         // value goes to zero
    // not a number: load with zero denominator, then arithmetic on it
    push_word(rau_pkg::MODE_LOAD, 5, 0);
    push_word(rau_pkg::MODE_ADD, 1, 2);
    push_word(rau_pkg::MODE_LOAD, 7, 3);
    push_word(rau_pkg::MODE_ADD, 1, 0);         // operand poisons the result
    push_word(rau_pkg::MODE_LOAD, 0, 0);
    // most negative word over minus one wraps
    push_word(rau_pkg::MODE_LOAD, MOST_NEG, -1);
    push_word(rau_pkg::MODE_DIV, -1, 1);
    push_word(rau_pkg::MODE_LOAD, MOST_NEG, MOST_NEG);
    push_word(rau_pkg::MODE_LOAD, MOST_POS, 2);
    push_word(rau_pkg::MODE_MUL, 2, 1);         // product wraps
    push_word(rau_pkg::MODE_DIV, 0, 5);         // division by a zero value
    // unused modes leave the accumulator alone
    push_word(rau_pkg::MODE_LOAD, -6, -4);
    push_word(MODE_SPARE_LO, -3, -2);
    push_word(MODE_SPARE_HI, $urandom, $urandom);

    // random part, with a quiet stretch and one full drain
    for (int i = 0; i < RAND_WORDS; i++) begin
      quiet = (i >= 200 && i < 260);
      if (i == 120) begin
        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
      end
      random_word();
    end
    s_tvalid <= 1'b0;
    quiet = 1'b0;

    // drain, then watch a while for stray results
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);

    $display("words sent: load %0d, add %0d, sub %0d, mul %0d, div %0d, cmp %0d, unused %0d",
             mode_count[rau_pkg::MODE_LOAD], mode_count[rau_pkg::MODE_ADD],
             mode_count[rau_pkg::MODE_SUB], mode_count[rau_pkg::MODE_MUL],
             mode_count[rau_pkg::MODE_DIV], mode_count[rau_pkg::MODE_CMP],
             mode_count[MODE_SPARE_LO] + mode_count[MODE_SPARE_HI]);
    $display("results checked: %0d (%0d not a number), mismatches: %0d",
             sb.checked, sb.nan_seen, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("** rational_arithmetic_unit: PASSED **");
    end else begin
      $display("** rational_arithmetic_unit: FAILED **");
    end
    $finish;
  end

endmodule
